// ===== rtl/pec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_pkg: shared types and constants of the printer escape code parser
// Byte codes, command codes, escape phases, the result record and the
// sizing of the result queue.
// ----------------------------------------------------------------------------
package pec_pkg;

  // Control bytes seen outside an escape sequence
  localparam logic [7:0] ChrLf        = 8'h0a;
  localparam logic [7:0] ChrFf        = 8'h0c;
  localparam logic [7:0] ChrCr        = 8'h0d;
  localparam logic [7:0] ChrExpand    = 8'h0e;
  localparam logic [7:0] ChrCondensed = 8'h0f;
  localparam logic [7:0] ChrCancelDc2 = 8'h12;
  localparam logic [7:0] ChrCancelDc4 = 8'h14;
  localparam logic [7:0] ChrEsc       = 8'h1b;

  // Bytes that follow ESC
  localparam logic [7:0] EscGraphics  = 8'h2a;
  localparam logic [7:0] EscUnderline = 8'h2d;
  localparam logic [7:0] EscSpacing   = 8'h33;
  localparam logic [7:0] EscItalicOn  = 8'h34;
  localparam logic [7:0] EscItalicOff = 8'h35;
  localparam logic [7:0] EscInit      = 8'h40;
  localparam logic [7:0] EscTabs      = 8'h44;
  localparam logic [7:0] EscBoldOn    = 8'h45;
  localparam logic [7:0] EscBoldOff   = 8'h46;
  localparam logic [7:0] EscQuality   = 8'h78;

  // Tab list terminator
  localparam logic [7:0] ChrNul = 8'h00;

  // Width modes
  localparam logic [1:0] WidthNormal   = 2'd0;
  localparam logic [1:0] WidthExpanded = 2'd1;
  localparam logic [1:0] WidthCondense = 2'd2;

  // Result queue sizing: one byte makes at most two results
  localparam int MaxRes = 2;
  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    CMD_CHAR       = 4'd0,
    CMD_CR         = 4'd1,
    CMD_LF         = 4'd2,
    CMD_PAGE       = 4'd3,
    CMD_WIDTH      = 4'd4,
    CMD_BOLD_ON    = 4'd5,
    CMD_BOLD_OFF   = 4'd6,
    CMD_ITALIC_ON  = 4'd7,
    CMD_ITALIC_OFF = 4'd8,
    CMD_COLUMN     = 4'd9,
    CMD_BAD_ESC    = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    PH_ENTERED   = 3'd0,
    PH_GRAPHICS  = 3'd1,
    PH_UNDERLINE = 3'd2,
    PH_SPACING   = 3'd3,
    PH_TABS      = 3'd4,
    PH_QUALITY   = 3'd5
  } phase_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  char_code;
    logic [1:0]  width_mode;
    logic [23:0] column_bits;
    logic        last;
  } result_t;

  // Decoder to queue: one decoded byte
  typedef struct packed {
    logic       push;
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
  } dec_out_t;

  // Queue status back to the top level
  typedef struct packed {
    logic            space_ok;
    logic [CntW-1:0] count;
  } q_stat_t;

  function automatic result_t mk_res(cmd_t cmd, logic [7:0] ch, logic [1:0] wm,
                                     logic [23:0] col);
    result_t r;
    r.command     = cmd;
    r.char_code   = ch;
    r.width_mode  = wm;
    r.column_bits = col;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/pec_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_decode: byte decoder and parser state
// Decodes one byte per step into up to two results and updates the escape,
// width and graphics state registers.
// ----------------------------------------------------------------------------
module pec_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        byte_in,
  output pec_pkg::dec_out_t dec_out
);

  logic              in_escape_r, in_escape_nxt;
  pec_pkg::phase_t   phase_r, phase_nxt;
  logic [1:0]        width_r, width_nxt;
  logic [17:0]       gcnt_r, gcnt_nxt;
  logic [15:0]       gcols_r, gcols_nxt;
  logic [15:0]       partial_r, partial_nxt;
  logic [1:0]        grp_r, grp_nxt;     // (gcnt - 3) mod 3 once past the header
  logic [17:0]       gcnt_inc;
  logic [17:0]       gend;

  // Graphics end point: 3 header bytes plus 3 bytes per column
  assign gcnt_inc = gcnt_r + 18'd1;
  assign gend     = {2'b00, gcols_r} + {1'b0, gcols_r, 1'b0} + 18'd3;

  // Next state and results
  always_comb begin
    in_escape_nxt   = in_escape_r;
    phase_nxt       = phase_r;
    width_nxt       = width_r;
    gcnt_nxt        = gcnt_r;
    gcols_nxt       = gcols_r;
    partial_nxt     = partial_r;
    grp_nxt         = grp_r;
    dec_out.push    = step_en;
    dec_out.n_res   = 2'd0;
    dec_out.res0    = '0;
    dec_out.res1    = '0;
    if (step_en) begin
      if (!in_escape_r) begin
        // Normal text stream
        unique case (byte_in) inside
          pec_pkg::ChrExpand: begin
            width_nxt     = pec_pkg::WidthExpanded;
            dec_out.n_res = 2'd1;
            dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_WIDTH, 8'd0,
                                            pec_pkg::WidthExpanded, 24'd0);
          end
          pec_pkg::ChrCancelDc4, pec_pkg::ChrCancelDc2: begin
            width_nxt     = pec_pkg::WidthNormal;
            dec_out.n_res = 2'd1;
            dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_WIDTH, 8'd0,
                                            pec_pkg::WidthNormal, 24'd0);
          end
          pec_pkg::ChrCondensed: begin
            width_nxt     = pec_pkg::WidthCondense;
            dec_out.n_res = 2'd1;
            dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_WIDTH, 8'd0,
                                            pec_pkg::WidthCondense, 24'd0);
          end
          pec_pkg::ChrCr: begin
            dec_out.n_res = 2'd1;
            dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_CR, 8'd0, 2'd0, 24'd0);
          end
          pec_pkg::ChrLf: begin
            // LF ends one-line expansion: width result first
            if (width_r == pec_pkg::WidthExpanded) begin
              width_nxt         = pec_pkg::WidthNormal;
              dec_out.n_res     = 2'd2;
              dec_out.res0      = pec_pkg::mk_res(pec_pkg::CMD_WIDTH, 8'd0,
                                                  pec_pkg::WidthNormal, 24'd0);
              dec_out.res0.last = 1'b0;
              dec_out.res1      = pec_pkg::mk_res(pec_pkg::CMD_LF, 8'd0, 2'd0, 24'd0);
            end else begin
              dec_out.n_res = 2'd1;
              dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_LF, 8'd0, 2'd0, 24'd0);
            end
          end
          pec_pkg::ChrFf: begin
            dec_out.n_res = 2'd1;
            dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_PAGE, 8'd0, 2'd0, 24'd0);
          end
          pec_pkg::ChrEsc: begin
            in_escape_nxt = 1'b1;
            phase_nxt     = pec_pkg::PH_ENTERED;
          end
          default: begin
            dec_out.n_res = 2'd1;
            dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_CHAR, byte_in, 2'd0, 24'd0);
          end
        endcase
      end else begin
        unique case (phase_r)
          pec_pkg::PH_ENTERED: begin
            // First byte after ESC
            unique case (byte_in) inside
              pec_pkg::EscBoldOn: begin
                dec_out.n_res = 2'd1;
                dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_BOLD_ON, 8'd0, 2'd0,
                                                24'd0);
              end
              pec_pkg::EscBoldOff: begin
                dec_out.n_res = 2'd1;
                dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_BOLD_OFF, 8'd0, 2'd0,
                                                24'd0);
              end
              pec_pkg::EscItalicOn: begin
                dec_out.n_res = 2'd1;
                dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_ITALIC_ON, 8'd0, 2'd0,
                                                24'd0);
              end
              pec_pkg::EscItalicOff: begin
                dec_out.n_res = 2'd1;
                dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_ITALIC_OFF, 8'd0, 2'd0,
                                                24'd0);
              end
              pec_pkg::EscGraphics: begin
                gcnt_nxt    = 18'd0;
                partial_nxt = 16'd0;
                grp_nxt     = 2'd0;
                phase_nxt   = pec_pkg::PH_GRAPHICS;
              end
              pec_pkg::EscUnderline: phase_nxt = pec_pkg::PH_UNDERLINE;
              pec_pkg::EscSpacing:   phase_nxt = pec_pkg::PH_SPACING;
              pec_pkg::EscInit:      phase_nxt = pec_pkg::PH_ENTERED;
              pec_pkg::EscTabs:      phase_nxt = pec_pkg::PH_TABS;
              pec_pkg::EscQuality:   phase_nxt = pec_pkg::PH_QUALITY;
              default: begin
                dec_out.n_res = 2'd1;
                dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_BAD_ESC, byte_in, 2'd0,
                                                24'd0);
              end
            endcase
            if (phase_nxt == pec_pkg::PH_ENTERED) begin
              in_escape_nxt = 1'b0;
            end
          end
          pec_pkg::PH_GRAPHICS: begin
            // Mode byte, count low, count high, then 3-byte columns
            if (gcnt_r == 18'd0) begin
              gcnt_nxt = 18'd1;
            end else if (gcnt_r == 18'd1) begin
              gcols_nxt = {8'd0, byte_in};
              gcnt_nxt  = 18'd2;
            end else if (gcnt_r == 18'd2) begin
              gcols_nxt = {byte_in, gcols_r[7:0]};
              gcnt_nxt  = 18'd3;
              if ({byte_in, gcols_r[7:0]} == 16'd0) begin
                in_escape_nxt = 1'b0;
              end
            end else begin
              case (grp_r)
                2'd0: begin
                  partial_nxt = {byte_in, 8'd0};
                  grp_nxt     = 2'd1;
                end
                2'd1: begin
                  partial_nxt = {partial_r[15:8], partial_r[7:0] | byte_in};
                  grp_nxt     = 2'd2;
                end
                default: begin
                  dec_out.n_res = 2'd1;
                  dec_out.res0  = pec_pkg::mk_res(pec_pkg::CMD_COLUMN, 8'd0, 2'd0,
                                                  {partial_r, byte_in});
                  partial_nxt   = 16'd0;
                  grp_nxt       = 2'd0;
                end
              endcase
              gcnt_nxt = gcnt_inc;
              if (gcnt_inc >= gend) begin
                in_escape_nxt = 1'b0;
              end
            end
          end
          pec_pkg::PH_TABS: begin
            if (byte_in == pec_pkg::ChrNul) begin
              in_escape_nxt = 1'b0;
            end
          end
          default: in_escape_nxt = 1'b0;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_escape_r <= 1'b0;
      phase_r     <= pec_pkg::PH_ENTERED;
      width_r     <= pec_pkg::WidthNormal;
      gcnt_r      <= 18'd0;
      gcols_r     <= 16'd0;
      partial_r   <= 16'd0;
      grp_r       <= 2'd0;
    end else begin
      in_escape_r <= in_escape_nxt;
      phase_r     <= phase_nxt;
      width_r     <= width_nxt;
      gcnt_r      <= gcnt_nxt;
      gcols_r     <= gcols_nxt;
      partial_r   <= partial_nxt;
      grp_r       <= grp_nxt;
    end
  end

endmodule

// ===== rtl/pec_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_out_queue: result queue
// Small flop queue that takes up to two results per cycle and hands out one
// per cycle on the result channel while it is not stalled.
// ----------------------------------------------------------------------------
module pec_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  pec_pkg::dec_out_t dec_out,
  input  logic              pop,
  output pec_pkg::result_t  head,
  output logic              head_valid,
  output pec_pkg::q_stat_t  stat
);

  localparam int PtrW = pec_pkg::PtrW;
  localparam int CntW = pec_pkg::CntW;

  pec_pkg::result_t  entry_r [pec_pkg::QDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [1:0]        n_wr;
  logic [PtrW-1:0]   wr_ptr_p1;

  assign n_wr      = dec_out.push ? dec_out.n_res : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + PtrW'(1);

  // Room for a worst-case byte, counting a pop in this cycle
  assign stat.space_ok = ({1'b0, count_r} + (CntW+1)'(pec_pkg::MaxRes)) <=
                         ((CntW+1)'(pec_pkg::QDepth) + (CntW+1)'(pop));
  assign stat.count    = count_r;

  assign head       = entry_r[rd_ptr_r];
  assign head_valid = (count_r != '0);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(n_wr);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(n_wr) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      entry_r[wr_ptr_r] <= dec_out.res0;
    end
    if (n_wr == 2'd2) begin
      entry_r[wr_ptr_p1] <= dec_out.res1;
    end
  end

endmodule

// ===== rtl/printer_escape_code_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printer_escape_code_parser_top: dot-matrix printer control code parser
// Takes one printer byte per request and returns characters, control
// commands, style changes and bit-image graphics columns.
// ----------------------------------------------------------------------------
//   channel | ports                                         | direction
//   input   | in_valid, in_stall, in_byte_in                | byte stream in
//   result  | out_valid, out_stall, out_command, out_char_code,
//           | out_width_mode, out_column_bits, out_last     | results out
//
// One byte per cycle while in_stall is low: a byte is held in the input
// register and is decoded as it moves into the result queue; its first result
// shows the cycle after. An LF ending one-line expansion gives two results,
// which the result port drains one per cycle, while out_stall is low, through
// the four-entry queue. Reset is synchronous and clears parser state and the
// queue. in_stall rises only while a held byte cannot enter the queue.
// ----------------------------------------------------------------------------
module printer_escape_code_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_command,
  output logic [7:0]  out_char_code,
  output logic [1:0]  out_width_mode,
  output logic [23:0] out_column_bits,
  output logic        out_last
);

  logic              in_valid_r, in_valid_nxt;
  logic [7:0]        in_byte_r;
  logic              in_take;
  logic              step_en;
  logic              pop;
  pec_pkg::dec_out_t dec_out;
  pec_pkg::result_t  head;
  pec_pkg::q_stat_t  q_stat;

  // Input register handshake
  assign step_en  = in_valid_r && q_stat.space_ok;
  assign in_stall = in_valid_r && !q_stat.space_ok;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte_in;
    end
  end

  // Decoder and parser state
  pec_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (in_byte_r),
    .dec_out (dec_out)
  );

  // Result queue
  assign pop = out_valid && !out_stall;

  pec_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec_out    (dec_out),
    .pop        (pop),
    .head       (head),
    .head_valid (out_valid),
    .stat       (q_stat)
  );

  assign out_command     = head.command;
  assign out_char_code   = head.char_code;
  assign out_width_mode  = head.width_mode;
  assign out_column_bits = head.column_bits;
  assign out_last        = head.last;

`ifndef NO_ASSERTIONS
  // Queue never overfills
  a_q_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= pec_pkg::CntW'(pec_pkg::QDepth))
    else $error("result queue overfilled");

  // Two results from one byte are always width then LF
  a_pair : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && dec_out.n_res == 2'd2) |->
      (dec_out.res0.command == pec_pkg::CMD_WIDTH &&
       dec_out.res1.command == pec_pkg::CMD_LF && !dec_out.res0.last))
    else $error("bad result pair");

  // A decoded byte with results makes the queue non-empty next cycle
  a_push_visible : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && dec_out.n_res != 2'd0) |=> out_valid)
    else $error("decoded result not queued");
`endif

endmodule

// ===== tb/pec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_checker: result checker for the printer escape code parser
// Watches both channels. Each accepted byte runs through a local decoder that
// tracks escape, width and graphics state and queues the commands that the
// byte should produce. Each accepted result is compared field by field
// against the oldest queued command.
// ----------------------------------------------------------------------------
module pec_checker
  import pec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_command,
  input  logic [7:0]  out_char_code,
  input  logic [1:0]  out_width_mode,
  input  logic [23:0] out_column_bits,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  // Commands still owed by the block, oldest first
  result_t expected_cmds[$];

  // Decoder state
  logic        in_esc;
  phase_t      esc_phase;
  logic [1:0]  width_now;
  logic [17:0] gfx_taken;
  logic [15:0] gfx_columns;
  logic [15:0] gfx_partial;

  int errors    = 0;
  int n_pending = 0;

  assign fail_count = errors;
  assign pending    = n_pending;

  function automatic result_t make_result(cmd_t cmd, logic [7:0] ch, logic [1:0] wm,
                                          logic [23:0] col);
    result_t r;
    r.command     = cmd;
    r.char_code   = ch;
    r.width_mode  = wm;
    r.column_bits = col;
    r.last        = 1'b1;
    return r;
  endfunction

  // Decode one byte and queue the commands it produces
  task automatic decode_byte(input logic [7:0] b);
    result_t made[$];
    result_t r;
    if (in_esc) begin
      if (esc_phase == PH_ENTERED) begin
        case (b)
          EscBoldOn:    made.push_back(make_result(CMD_BOLD_ON, 8'h00, WidthNormal, 24'h0));
          EscBoldOff:   made.push_back(make_result(CMD_BOLD_OFF, 8'h00, WidthNormal, 24'h0));
          EscItalicOn:  made.push_back(make_result(CMD_ITALIC_ON, 8'h00, WidthNormal, 24'h0));
          EscItalicOff: made.push_back(make_result(CMD_ITALIC_OFF, 8'h00, WidthNormal, 24'h0));
          EscGraphics: begin
            gfx_taken   = '0;
            gfx_partial = '0;
            esc_phase   = PH_GRAPHICS;
          end
          EscUnderline: esc_phase = PH_UNDERLINE;
          EscSpacing:   esc_phase = PH_SPACING;
          EscInit:      ;
          EscTabs:      esc_phase = PH_TABS;
          EscQuality:   esc_phase = PH_QUALITY;
          default:      made.push_back(make_result(CMD_BAD_ESC, b, WidthNormal, 24'h0));
        endcase
        if (esc_phase == PH_ENTERED) in_esc = 1'b0;
      end else if (esc_phase == PH_GRAPHICS) begin
        if (gfx_taken == 0) begin
          // mode byte, ignored
          gfx_taken = 18'd1;
        end else if (gfx_taken == 1) begin
          gfx_columns = {8'h00, b};
          gfx_taken   = 18'd2;
        end else if (gfx_taken == 2) begin
          gfx_columns = gfx_columns | {b, 8'h00};
          gfx_taken   = 18'd3;
          if (gfx_columns == 0) in_esc = 1'b0;
        end else begin
          // three bytes per column, first byte most significant
          case ((int'(gfx_taken) - 3) % 3)
            0: gfx_partial = {b, 8'h00};
            1: gfx_partial = gfx_partial | {8'h00, b};
            default: begin
              made.push_back(make_result(CMD_COLUMN, 8'h00, WidthNormal, {gfx_partial, b}));
              gfx_partial = '0;
            end
          endcase
          gfx_taken = gfx_taken + 18'd1;
          if (int'(gfx_taken) >= int'(gfx_columns) * 3 + 3) in_esc = 1'b0;
        end
      end else if (esc_phase == PH_TABS) begin
        if (b == ChrNul) in_esc = 1'b0;
      end else begin
        // single argument byte, consumed
        in_esc = 1'b0;
      end
    end else begin
      case (b)
        ChrExpand: begin
          width_now = WidthExpanded;
          made.push_back(make_result(CMD_WIDTH, 8'h00, WidthExpanded, 24'h0));
        end
        ChrCancelDc4, ChrCancelDc2: begin
          width_now = WidthNormal;
          made.push_back(make_result(CMD_WIDTH, 8'h00, WidthNormal, 24'h0));
        end
        ChrCondensed: begin
          width_now = WidthCondense;
          made.push_back(make_result(CMD_WIDTH, 8'h00, WidthCondense, 24'h0));
        end
        ChrCr: made.push_back(make_result(CMD_CR, 8'h00, WidthNormal, 24'h0));
        ChrLf: begin
          // LF ends one-line expansion
          if (width_now == WidthExpanded) begin
            width_now = WidthNormal;
            made.push_back(make_result(CMD_WIDTH, 8'h00, WidthNormal, 24'h0));
          end
          made.push_back(make_result(CMD_LF, 8'h00, WidthNormal, 24'h0));
        end
        ChrFf: made.push_back(make_result(CMD_PAGE, 8'h00, WidthNormal, 24'h0));
        ChrEsc: begin
          in_esc    = 1'b1;
          esc_phase = PH_ENTERED;
        end
        default: made.push_back(make_result(CMD_CHAR, b, WidthNormal, 24'h0));
      endcase
    end
    // only the final command of a byte carries last
    foreach (made[i]) begin
      r      = made[i];
      r.last = (i == made.size() - 1);
      expected_cmds.push_back(r);
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      in_esc      = 1'b0;
      esc_phase   = PH_ENTERED;
      width_now   = WidthNormal;
      gfx_taken   = '0;
      gfx_columns = '0;
      gfx_partial = '0;
      expected_cmds.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte_in);
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          errors++;
          // actual fields: command/char/width/column/last
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0h/%0d",
                   $time, out_command, out_char_code, out_width_mode, out_column_bits,
                   out_last);
        end else begin
          want = expected_cmds.pop_front();
          check_field("command", int'(want.command), int'(out_command));
          check_field("char_code", int'(want.char_code), int'(out_char_code));
          check_field("width_mode", int'(want.width_mode), int'(out_width_mode));
          check_field("column_bits", int'(want.column_bits), int'(out_column_bits));
          check_field("last", int'(want.last), int'(out_last));
        end
      end
    end
    n_pending = expected_cmds.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the printer escape code parser
// Sends directed bytes for every control code and some escapes, then random
// streams of characters, control codes, escape sequences and graphics with
// random content, with random idling on both sides and one long receiver
// hold-off. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import pec_pkg::*;

  localparam int ByteTarget = 1450;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_byte_in = 8'h00;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  out_command;
  logic [7:0]  out_char_code;
  logic [1:0]  out_width_mode;
  logic [23:0] out_column_bits;
  logic        out_last;

  int fail_count;
  int pending;
  int bytes_sent = 0;
  bit idle_on    = 1'b1;
  bit hold_req   = 1'b0;

  always #5 clk = ~clk;

  printer_escape_code_parser_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command     (out_command),
    .out_char_code   (out_char_code),
    .out_width_mode  (out_width_mode),
    .out_column_bits (out_column_bits),
    .out_last        (out_last)
  );

  pec_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command     (out_command),
    .out_char_code   (out_char_code),
    .out_width_mode  (out_width_mode),
    .out_column_bits (out_column_bits),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Run limit
  initial begin : watchdog
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Offer one request and hold it until taken, then maybe idle a while
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid   <= 1'b0;
      in_byte_in <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_escape(input logic [7:0] op);
    send_byte(ChrEsc);
    send_byte(op);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int cols;
    bit big_done;
    logic [7:0] b;
    big_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: character extremes, every control code, some escapes
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h41);
    send_byte(ChrCr);
    send_byte(ChrLf);
    send_byte(ChrFf);
    send_byte(ChrExpand);
    send_byte(ChrLf);          // width reset then LF
    send_byte(ChrCondensed);
    send_byte(ChrCancelDc2);
    send_byte(ChrCancelDc4);
    send_escape(EscBoldOn);
    send_escape(EscBoldOff);
    send_escape(EscItalicOn);
    send_escape(EscItalicOff);
    send_escape(EscInit);      // initialize, no result
    send_escape(8'hff);        // unknown escape
    send_escape(EscGraphics);  // zero column count
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);

    // Long receiver hold-off while printable bytes keep coming
    hold_req = 1'b1;
    repeat (30) send_byte(8'($urandom_range(8'h20, 8'hff)));

    // Random streams
    while (bytes_sent < ByteTarget) begin
      if (bytes_sent > ByteTarget - 200) idle_on = 1'b0;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
        else send_byte(8'($urandom_range(8'h20, 8'hff)));
      end else if (kind < 40) begin
        case ($urandom_range(0, 6))
          0: send_byte(ChrCr);
          1: send_byte(ChrLf);
          2: send_byte(ChrFf);
          3: begin
            send_byte(ChrExpand);
            if ($urandom_range(0, 1) == 1) send_byte(ChrLf);
          end
          4: send_byte(ChrCondensed);
          5: send_byte(ChrCancelDc2);
          default: send_byte(ChrCancelDc4);
        endcase
      end else if (kind < 55) begin
        case ($urandom_range(0, 4))
          0: send_escape(EscBoldOn);
          1: send_escape(EscBoldOff);
          2: send_escape(EscItalicOn);
          3: send_escape(EscItalicOff);
          default: send_escape(EscInit);
        endcase
      end else if (kind < 63) begin
        // escapes with one ignored argument
        case ($urandom_range(0, 2))
          0: send_escape(EscUnderline);
          1: send_escape(EscSpacing);
          default: send_escape(EscQuality);
        endcase
        send_byte(8'($urandom));
      end else if (kind < 69) begin
        // zero-terminated tab list
        send_escape(EscTabs);
        n = $urandom_range(0, 4);
        repeat (n) send_byte(8'($urandom_range(1, 255)));
        send_byte(ChrNul);
      end else if (kind < 90) begin
        // bit-image graphics, mostly short, once 256 columns
        send_escape(EscGraphics);
        send_byte(8'($urandom));
        if (!big_done && bytes_sent > 600) begin
          cols     = 256;
          big_done = 1'b1;
        end else begin
          n = $urandom_range(0, 9);
          if (n == 0) cols = 0;
          else if (n < 8) cols = $urandom_range(1, 8);
          else cols = $urandom_range(9, 40);
        end
        send_byte(8'(cols));
        send_byte(8'(cols >> 8));
        repeat (cols * 3) send_byte(8'($urandom));
      end else begin
        // broken escape: random byte after ESC, no long-running sequences
        do b = 8'($urandom); while (b == EscGraphics || b == EscTabs);
        send_escape(b);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pec_pkg.sv
rtl/pec_decode.sv
rtl/pec_out_queue.sv
rtl/printer_escape_code_parser_top.sv
tb/pec_checker.sv
tb/tb_top.sv
